// ===== sv/skfb_pkg.sv =====
// ----------------------------------------------------------------------------
// Scalar Kalman filter bank package
// Shared widths, defaults and the sequencer state type for the filter bank.
// ----------------------------------------------------------------------------
`default_nettype none

package skfb_pkg;

  // Field widths fixed by the stream format.
  localparam int DATA_W      = 32;
  localparam int CHAN_W      = 3;
  localparam int GAIN_BITS   = 17;          // unsigned Q1.16, 65536 is one
  localparam int GAIN_SHIFT  = 16;
  localparam int S_TDATA_W   = 4 * DATA_W;  // 128
  localparam int M_TDATA_W   = 88;          // 81 bits of fields, padded to bytes

  // Step counter for the serial divide and multiply loop.
  localparam int STEP_CNT_W  = 5;

  // Parameter defaults for the top level.
  localparam int CHANNELS_DEF      = 8;
  localparam int FRACTION_BITS_DEF = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_SETUP,
    ST_ITER,
    ST_FIN1,
    ST_FIN2
  } state_t;

endpackage : skfb_pkg

`default_nettype wire

// ===== sv/scalar_kalman_filter_bank_core.sv =====
// ----------------------------------------------------------------------------
// Scalar Kalman filter bank core
// Per-channel 1-D Kalman update in fixed point, bit-serial gain and products.
// ----------------------------------------------------------------------------
// Each input beat names a channel and carries the prior estimate x, the
// measurement z, and the noise variances Q and R. The core adds Q to the
// channel's stored covariance (or to initial_covariance on the channel's first
// use), forms the gain K = p / (p + R) in Q1.16, and returns the saturated
// posterior x + K(z - x) together with K and the new covariance (1 - K)p,
// which is also stored. The covariance is read at the accepting edge; the
// core then does the noise and denominator adds, runs the restoring divider
// that produces one gain bit per cycle (the two products are accumulated
// alongside it, one gain bit per cycle), and then rounds, saturates,
// loads the result register and writes back. A new beat is accepted as
// soon as the core is back in idle, which it enters as the result register
// is loaded, so no beat is taken while another is in process, though one is
// taken while the previous result still waits on the output; a stalled
// output holds the core in its last step until the result register is free.
// A zero denominator yields a zero gain. Channel numbers at or above
// CHANNELS are reduced modulo CHANNELS.
`default_nettype none

module scalar_kalman_filter_bank_core #(
  parameter int CHANNELS      = skfb_pkg::CHANNELS_DEF,
  parameter int FRACTION_BITS = skfb_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Configuration write channel: initial_covariance.
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [skfb_pkg::DATA_W-1:0]     cfg_data,
  // Input stream.
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // s_tdata: prior_estimate[31:0], measurement[63:32], process_noise[95:64],
  //          measurement_noise[127:96]
  input  wire logic [skfb_pkg::S_TDATA_W-1:0]  s_tdata,
  // s_tuser: channel[2:0]
  input  wire logic [skfb_pkg::CHAN_W-1:0]     s_tuser,
  // Output stream.
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // m_tdata: posterior_estimate[31:0], gain[48:32], covariance_out[80:49],
  //          zero[87:81]
  output logic [skfb_pkg::M_TDATA_W-1:0]       m_tdata,
  // m_tuser: channel_out[2:0]
  output logic [skfb_pkg::CHAN_W-1:0]          m_tuser
);

  import skfb_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [8:0] CHANNELS_V = 9'(CHANNELS);
  localparam logic [DATA_W-1:0] INIT_COV_RESET = DATA_W'(1) << FRACTION_BITS;

  state_t state, state_next;

  logic [DATA_W-1:0]     init_cov;
  logic [DATA_W-1:0]     cov_mem [CHANNELS];
  logic [CHANNELS-1:0]   started;
  logic [DATA_W-1:0]     cov_rd;
  logic                  started_rd;

  logic [CHAN_W-1:0]     ch_red;
  logic [8:0]            ch_ext;
  logic [IDX_W-1:0]      ch_idx;

  logic [CHAN_W-1:0]     ch_r;
  logic [IDX_W-1:0]      idx_r;
  logic [DATA_W-1:0]     x_r;
  logic [DATA_W-1:0]     z_r;
  logic [DATA_W-1:0]     q_r;
  logic [DATA_W-1:0]     r_r;
  logic [DATA_W:0]       e_r;
  logic [DATA_W-1:0]     p1;
  logic [DATA_W:0]       d_r;
  logic                  d_zero;
  logic [DATA_W:0]       rem;
  logic [GAIN_BITS-1:0]  div_bits;
  logic [GAIN_BITS-1:0]  quot;
  logic [50:0]           acc_e;
  logic [48:0]           acc_p;
  logic [STEP_CNT_W-1:0] step;
  logic [35:0]           post_wide;
  logic [DATA_W-1:0]     ceil_r;

  logic                  s_fire;
  logic                  out_free;
  logic [DATA_W:0]       p_sum;
  logic [DATA_W-1:0]     p_sel;
  logic [DATA_W+1:0]     trial;
  logic [DATA_W+1:0]     trial_diff;
  logic                  take;
  logic [49:0]           ceil_sum;
  logic [DATA_W-1:0]     post_sat;
  logic [DATA_W-1:0]     p2;

  assign cfg_ready = 1'b1;
  assign s_fire    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // Channel numbers are narrow, so the modulo is a few compare-subtract steps.
  always_comb begin
    ch_red = s_tuser;
    for (int i = 0; i < 7; i++) begin
      if ({6'b0, ch_red} >= CHANNELS_V) begin
        ch_red = ch_red - CHANNELS_V[CHAN_W-1:0];
      end
    end
    ch_ext = {6'b0, ch_red};
    ch_idx = ch_ext[IDX_W-1:0];
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM:   state_next = ST_SETUP;
      ST_SETUP: state_next = ST_ITER;
      ST_ITER: begin
        if (step == STEP_CNT_W'(GAIN_BITS - 1)) begin
          state_next = ST_FIN1;
        end
      end
      ST_FIN1:  state_next = ST_FIN2;
      ST_FIN2: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_cov <= INIT_COV_RESET;
    end else if (cfg_valid) begin
      init_cov <= cfg_data;
    end
  end

  // Datapath arithmetic for the individual sequencer steps.
  always_comb begin
    p_sel      = started_rd ? cov_rd : init_cov;
    p_sum      = {1'b0, p_sel} + {1'b0, q_r};
    trial      = {rem, div_bits[GAIN_BITS-1]};
    trial_diff = trial - {1'b0, d_r};
    take       = !d_zero && (trial >= {1'b0, d_r});
    ceil_sum   = {1'b0, acc_p} + 50'(16'hFFFF);
    if (post_wide[35] && !(&post_wide[34:31])) begin
      post_sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else if (!post_wide[35] && (|post_wide[34:31])) begin
      post_sat = {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      post_sat = post_wide[DATA_W-1:0];
    end
    p2 = p1 - ceil_r;
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_fire) begin
          ch_r       <= ch_red;
          idx_r      <= ch_idx;
          x_r        <= s_tdata[31:0];
          z_r        <= s_tdata[63:32];
          q_r        <= s_tdata[95:64];
          r_r        <= s_tdata[127:96];
          cov_rd     <= cov_mem[ch_idx];
          started_rd <= started[ch_idx];
        end
      end
      ST_SUM: begin
        p1  <= p_sum[DATA_W] ? {DATA_W{1'b1}} : p_sum[DATA_W-1:0];
        e_r <= {z_r[DATA_W-1], z_r} - {x_r[DATA_W-1], x_r};
      end
      ST_SETUP: begin
        d_r      <= {1'b0, p1} + {1'b0, r_r};
        d_zero   <= (p1 == '0) && (r_r == '0);
        // The top of the dividend p1 * 2^16 is below the divisor, so the
        // partial remainder starts with everything above the quotient bits.
        rem      <= {2'b0, p1[DATA_W-1:1]};
        div_bits <= {p1[0], {(GAIN_BITS-1){1'b0}}};
        quot     <= '0;
        acc_e    <= '0;
        acc_p    <= '0;
        step     <= '0;
      end
      ST_ITER: begin
        rem      <= take ? trial_diff[DATA_W:0] : trial[DATA_W:0];
        div_bits <= {div_bits[GAIN_BITS-2:0], 1'b0};
        quot     <= {quot[GAIN_BITS-2:0], take};
        // Gain bits arrive most significant first, so both products follow
        // Horner's rule.
        acc_e    <= {acc_e[49:0], 1'b0} + (take ? {{18{e_r[DATA_W]}}, e_r} : 51'd0);
        acc_p    <= {acc_p[47:0], 1'b0} + (take ? {17'b0, p1} : 49'd0);
        step     <= step + 1'b1;
      end
      ST_FIN1: begin
        post_wide <= {{4{x_r[DATA_W-1]}}, x_r} + {acc_e[50], acc_e[50:16]};
        // (1 - K) p rounded down equals p minus K p rounded up.
        ceil_r    <= ceil_sum[47:16];
      end
      ST_FIN2: begin
        if (out_free) begin
          cov_mem[idx_r] <= p2;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= '0;
    end else if (state == ST_FIN2 && out_free) begin
      started[idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FIN2 && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN2 && out_free) begin
      m_tdata <= {7'b0, p2, quot, post_sat};
      m_tuser <= ch_r;
    end
  end

  // The gain never exceeds one.
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN2 |-> quot <= GAIN_BITS'(65536))
    else $error("gain above one");

  // The updated covariance never grows past the predicted one.
  a_cov_shrinks: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN2 |-> ceil_r <= p1)
    else $error("covariance correction larger than covariance");

  // A zero denominator must come out of the divider as a zero gain.
  a_zero_den: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN1 && d_zero |-> quot == '0 && acc_p == '0)
    else $error("nonzero gain with zero denominator");

endmodule : scalar_kalman_filter_bank_core

`default_nettype wire
